/* design/dad_pkg.sv */
// dad_pkg: shared types, constants and month-length function for the
// calendar date adder. No dependencies.
package dad_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int CountW = 16;
  localparam int SumW   = CountW + 1;

  localparam logic [YearW-1:0]  MaxYear  = YearW'(9999);
  localparam logic [MonthW-1:0] January  = MonthW'(1);
  localparam logic [MonthW-1:0] February = MonthW'(2);
  localparam logic [MonthW-1:0] April    = MonthW'(4);
  localparam logic [MonthW-1:0] June     = MonthW'(6);
  localparam logic [MonthW-1:0] September = MonthW'(9);
  localparam logic [MonthW-1:0] November = MonthW'(11);
  localparam logic [MonthW-1:0] December = MonthW'(12);
  localparam logic [DayW-1:0]   LastDay  = DayW'(31);

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } dad_cmd_t;

  typedef struct packed {
    logic done;
  } dad_status_t;

  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] month,
                                                   input logic [1:0] year_low);
    logic [DayW-1:0] len;
    case (month) inside
      February: len = (year_low == 2'd0) ? DayW'(29) : DayW'(28);
      April, June, September, November: len = DayW'(30);
      default: len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

/* design/dad_ctrl.sv */
// dad_ctrl: controller for the date adder; sequences load, month steps and
// result capture. Depends on dad_pkg.
module dad_ctrl import dad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  input  dad_status_t status,
  output dad_cmd_t    cmd
);

  typedef enum logic [0:0] {
    IDLE,
    RUN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: cmd.load = req_valid;
      RUN: begin
        cmd.step    = !status.done;
        cmd.capture = status.done && out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (cmd.capture) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* design/dad_dpath.sv */
// dad_dpath: working date registers, one-month-per-cycle step and result
// registers for the date adder. Depends on dad_pkg.
module dad_dpath import dad_pkg::*; (
  input  logic              clk,
  input  dad_cmd_t          cmd,
  output dad_status_t       status,
  input  logic [DayW-1:0]   start_day,
  input  logic [MonthW-1:0] start_month,
  input  logic [YearW-1:0]  start_year,
  input  logic [CountW-1:0] add_count,
  output logic [DayW-1:0]   end_day,
  output logic [MonthW-1:0] end_month,
  output logic [YearW-1:0]  end_year,
  output logic              year_overflow
);

  logic [SumW-1:0]   sum;
  logic [MonthW-1:0] month;
  logic [YearW-1:0]  year;
  logic              ovf;

  logic [DayW-1:0]   len;
  logic [DayW-1:0]   day_in;
  logic [MonthW-1:0] month_in;

  assign len         = month_length(month, year[1:0]);
  assign status.done = ovf || (sum <= SumW'(len));

  always_comb begin
    day_in = (start_day == '0) ? DayW'(1) : start_day;
    if (start_month == '0) begin
      month_in = January;
    end else if (start_month > December) begin
      month_in = December;
    end else begin
      month_in = start_month;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum   <= SumW'(day_in) + SumW'(add_count);
      month <= month_in;
      year  <= start_year;
      ovf   <= (start_year > MaxYear);
    end else if (cmd.step) begin
      sum <= sum - SumW'(len);
      if (month == December) begin
        month <= January;
        if (year >= MaxYear) begin
          ovf <= 1'b1;
        end else begin
          year <= year + YearW'(1);
        end
      end else begin
        month <= month + MonthW'(1);
      end
    end
    if (cmd.capture) begin
      if (ovf) begin
        end_day   <= LastDay;
        end_month <= December;
        end_year  <= MaxYear;
      end else begin
        end_day   <= sum[DayW-1:0];
        end_month <= month;
        end_year  <= year;
      end
      year_overflow <= ovf;
    end
  end

endmodule

/* design/date_add_days.sv */
// date_add_days: top level of the calendar date adder; joins controller and
// datapath. Depends on dad_pkg, dad_ctrl, dad_dpath.
//
//   channel  handshake             payload
//   request  req_valid, req_stall  start_day, start_month, start_year, add_count
//   response rsp_valid, rsp_stall  end_day, end_month, end_year, year_overflow
//
// One request is worked at a time. It is loaded, then stepped once per
// month crossed by the month-step loop (up to about 2160 months for 65535 days),
// and then the result is moved into the response register.
// Reset clears the controller; the next request is taken in the cycle after
// capture, even while the response is still stalled.
// A stalled response holds the result, and the loop finishes and waits.
module date_add_days import dad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [DayW-1:0]   start_day,
  input  logic [MonthW-1:0] start_month,
  input  logic [YearW-1:0]  start_year,
  input  logic [CountW-1:0] add_count,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [DayW-1:0]   end_day,
  output logic [MonthW-1:0] end_month,
  output logic [YearW-1:0]  end_year,
  output logic              year_overflow
);

  dad_cmd_t    cmd;
  dad_status_t status;

  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dad_dpath u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .add_count     (add_count),
    .end_day       (end_day),
    .end_month     (end_month),
    .end_year      (end_year),
    .year_overflow (year_overflow)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for date_add_days. Sends date requests with random
// gaps, stalls the response side, and checks each result against a local date predictor.
// Depends on dad_pkg and date_add_days.
module tb;
  import dad_pkg::*;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              overflow;
  } end_date_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic [DayW-1:0]   start_day;
  logic [MonthW-1:0] start_month;
  logic [YearW-1:0]  start_year;
  logic [CountW-1:0] add_count;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [DayW-1:0]   end_day;
  logic [MonthW-1:0] end_month;
  logic [YearW-1:0]  end_year;
  logic              year_overflow;

  end_date_t   expected_dates[$];
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          valid_held = 1'b0;
  int unsigned stall_left = 0;
  bit          stall_level = 1'b0;

  date_add_days dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .start_day(start_day),
    .start_month(start_month),
    .start_year(start_year),
    .add_count(add_count),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .end_day(end_day),
    .end_month(end_month),
    .end_year(end_year),
    .year_overflow(year_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned days_in_month(int unsigned mon, int unsigned yr);
    if (mon == int'(February)) return (yr % 4 == 0) ? 29 : 28;
    if (mon == int'(April) || mon == int'(June) || mon == int'(September) ||
        mon == int'(November)) return 30;
    return 31;
  endfunction

  function automatic end_date_t predict_end_date(logic [DayW-1:0] d, logic [MonthW-1:0] m,
                                                 logic [YearW-1:0] y, logic [CountW-1:0] c);
    end_date_t   r;
    int unsigned day_sum;
    int unsigned mon;
    int unsigned yr;
    bit          ovf;
    mon = (m == 0) ? 1 : ((m > 12) ? 12 : m);
    yr = y;
    ovf = (yr > int'(MaxYear));
    day_sum = ((d == 0) ? 1 : d) + c;
    if (!ovf) begin
      while (day_sum > days_in_month(mon, yr)) begin
        day_sum -= days_in_month(mon, yr);
        mon++;
        if (mon > 12) begin
          mon = 1;
          if (yr >= int'(MaxYear)) begin
            ovf = 1'b1;
            break;
          end
          yr++;
        end
      end
    end
    if (ovf) begin
      r.day = LastDay;
      r.month = December;
      r.year = MaxYear;
    end else begin
      r.day = DayW'(day_sum);
      r.month = MonthW'(mon);
      r.year = YearW'(yr);
    end
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  task automatic send_request(int unsigned d, int unsigned m, int unsigned y, int unsigned c);
    int unsigned gap;
    req_valid <= 1'b1;
    start_day <= DayW'(d);
    start_month <= MonthW'(m);
    start_year <= YearW'(y);
    add_count <= CountW'(c);
    do @(posedge clk); while (req_stall);
    expected_dates.push_back(predict_end_date(DayW'(d), MonthW'(m), YearW'(y), CountW'(c)));
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 8);
      req_valid <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      if (burst_left > 0) burst_left--;
      valid_held = 1'b1;
    end
  endtask

  // response stall pattern: free runs alternate with stall runs of varying length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_level = !stall_level;
      if (stall_level) begin
        case ($urandom_range(0, 3))
          0: stall_left = 0;
          1: stall_left = $urandom_range(1, 3);
          2: stall_left = $urandom_range(1, 8);
          default: stall_left = $urandom_range(8, 16);
        endcase
        if (stall_left == 0) stall_level = 1'b0;
      end else begin
        stall_left = $urandom_range(1, 60);
      end
    end
    if (stall_left > 0) stall_left--;
    rsp_stall <= stall_level;
  end

  always @(posedge clk) begin
    end_date_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_dates.size() == 0) begin
        $display("[%0t] unexpected result %0d-%0d-%0d", $time, end_year, end_month, end_day);
        error_count++;
      end else begin
        want = expected_dates.pop_front();
        if (end_day !== want.day) report_mismatch("end_day", end_day, want.day);
        if (end_month !== want.month) report_mismatch("end_month", end_month, want.month);
        if (end_year !== want.year) report_mismatch("end_year", end_year, want.year);
        if (year_overflow !== want.overflow)
          report_mismatch("year_overflow", year_overflow, want.overflow);
      end
    end
  end

  task automatic test_field_extremes();
    send_request(1, 1, 0, 0);
    send_request(31, 12, 9999, 0);
    send_request(1, 1, 0, 65535);
    send_request(31, 12, 9998, 65535);
    send_request(31, 12, 0, 1);
    send_request(30, 4, 1, 1);
    send_request(30, 11, 7777, 31);
  endtask

  task automatic test_special_cases();
    send_request(0, 3, 100, 0);
    send_request(0, 0, 0, 0);
    send_request(15, 13, 50, 20);
    send_request(31, 15, 0, 1);
    send_request(31, 2, 1, 0);
    send_request(30, 2, 4, 0);
    send_request(10, 6, 10000, 5);
    send_request(31, 15, 16383, 65535);
    send_request(31, 12, 9999, 1);
    send_request(1, 12, 9999, 30);
    send_request(1, 1, 9999, 365);
  endtask

  task automatic test_leap_years();
    send_request(28, 2, 2024, 1);
    send_request(28, 2, 2023, 1);
    send_request(28, 2, 2000, 1);
    send_request(28, 2, 1900, 1);
    send_request(1, 1, 0, 366);
  endtask

  task automatic test_random_dates(int unsigned num_requests);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned c;
    for (int unsigned i = 0; i < num_requests; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      d = $urandom_range(0, 31);
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      case ($urandom_range(0, 19))
        0: y = $urandom_range(10000, 16383);
        1, 2: y = $urandom_range(9990, 9999);
        default: y = $urandom_range(0, 9999);
      endcase
      case ($urandom_range(0, 9))
        0: c = $urandom_range(0, 65535);
        1: c = $urandom_range(0, 3000);
        default: c = $urandom_range(0, 400);
      endcase
      send_request(d, m, y, c);
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    start_day <= '0;
    start_month <= '0;
    start_year <= '0;
    add_count <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gaps_on = 1'b0;
    test_field_extremes();
    gaps_on = 1'b1;
    test_special_cases();
    test_leap_years();
    test_random_dates(250);
    if (valid_held) req_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (expected_dates.size() != 0) begin
      $display("%0d results never arrived", expected_dates.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
design/dad_pkg.sv
design/dad_ctrl.sv
design/dad_dpath.sv
design/date_add_days.sv
tb/tb.sv
